// ===== sv/edsc_pkg.sv =====
// constants and types for the der signature canonicality checker
// group order of secp256k1, der tags and length limits, parse phases, verdict codes
// no dependencies
package edsc_pkg;

  // secp256k1 group order and its half, rounded down
  localparam logic [255:0] GROUP_ORDER =
    256'hFFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFE_BAAEDCE6_AF48A03B_BFD25E8C_D0364141;
  localparam logic [255:0] GROUP_HALF = (GROUP_ORDER - 256'd1) >> 1;

  // der framing
  localparam logic [7:0] SEQ_TAG   = 8'h30;
  localparam logic [7:0] INT_TAG   = 8'h02;
  localparam logic [7:0] INT_LEN_MAX = 8'd33;
  localparam logic [5:0] PART_LEN_MAX = 6'd33;
  localparam logic [6:0] SIG_LEN_MAX = 7'd72;
  localparam logic [7:0] SIG_LEN_MIN = 8'd8;

  // parse phase, one-hot
  typedef enum logic [7:0] {
    PH_HDR_TAG = 8'b0000_0001,
    PH_HDR_LEN = 8'b0000_0010,
    PH_R_TAG   = 8'b0000_0100,
    PH_R_LEN   = 8'b0000_1000,
    PH_R_DATA  = 8'b0001_0000,
    PH_S_TAG   = 8'b0010_0000,
    PH_S_LEN   = 8'b0100_0000,
    PH_S_DATA  = 8'b1000_0000
  } phase_t;

  // result codes
  typedef enum logic [1:0] {
    VERDICT_INVALID   = 2'd0,
    VERDICT_CANONICAL = 2'd1,
    VERDICT_LOW_S     = 2'd2
  } verdict_t;

endpackage

// ===== sv/ecdsa_der_signature_canonicality.sv =====
// byte-serial canonicality check of a der-encoded secp256k1 ecdsa signature
// depends on edsc_pkg for the group order, der constants, phase and verdict types
//
// Takes one signature byte per transaction on the in_ channel, in_last_byte marking
// the final byte, and gives one out_verdict transaction per signature: 0 invalid,
// 1 canonical, 2 canonical with low s. Bytes are taken one per cycle back to back
// while in_ready is high; each byte passes an input register, then the parse step,
// integer accumulation and the constant 256-bit compares against the group order
// and its half, then the result register; a final byte waits in the input register
// while the previous verdict has not yet left the result register. in_ready drops
// only while a final byte sits in the input register and the previous verdict has
// not yet been taken. After each final byte the parser is back in its reset state
// for the next signature.
module ecdsa_der_signature_canonicality (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_sig_byte,
  input  logic       in_last_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_verdict
);
  import edsc_pkg::*;

  // input register
  logic       in_v_r;
  logic [7:0] byte_r;
  logic       last_r;

  // parser state
  logic [6:0]   byte_count_r, byte_count_nxt;
  logic [7:0]   decl_len_r, decl_len_nxt;
  phase_t       phase_r, phase_nxt;
  logic [5:0]   part_rem_r, part_rem_nxt;
  logic         fbz_r, fbz_nxt;
  logic [255:0] r_value_r, r_value_nxt;
  logic [255:0] s_value_r, s_value_nxt;
  logic         failed_r, failed_nxt;

  // result register
  logic     out_v_r;
  verdict_t verdict_r;

  logic         out_free;
  logic         proc;
  logic         fail_pre;
  logic [255:0] acc_sel;
  logic         acc_zero;
  logic [255:0] acc_shift;
  logic         td_fail;
  logic         td_fbz;
  logic [5:0]   td_rem;
  logic [7:0]   total;
  logic         len_bad;
  logic         sig_ok;
  verdict_t     verdict_nxt;

  // flow control: only a final byte needs room in the result register
  assign out_free = !out_v_r || out_ready;
  assign proc     = in_v_r && (!last_r || out_free);
  assign in_ready = !in_v_r || proc;

  assign out_valid   = out_v_r;
  assign out_verdict = verdict_r;

  // integer data byte: sign, zero and padding checks, shift into accumulator
  assign acc_sel   = (phase_r == PH_R_DATA) ? r_value_r : s_value_r;
  assign acc_zero  = ~|acc_sel;
  assign acc_shift = {acc_sel[247:0], byte_r};
  assign td_rem    = (part_rem_r == 6'd0) ? 6'd0 : part_rem_r - 6'd1;

  always_comb begin
    td_fail = 1'b0;
    td_fbz  = fbz_r;
    if (acc_zero && !fbz_r) begin
      if (byte_r[7]) begin
        td_fail = 1'b1;
      end else if (byte_r == 8'd0) begin
        if (part_rem_r == 6'd1) td_fail = 1'b1;
        td_fbz = 1'b1;
      end else if (part_rem_r == PART_LEN_MAX) begin
        td_fail = 1'b1;
      end
    end else if (fbz_r && acc_zero) begin
      if (!byte_r[7]) td_fail = 1'b1;
    end
  end

  assign len_bad  = (byte_r == 8'd0) || (byte_r > INT_LEN_MAX);
  assign fail_pre = failed_r || (byte_count_r >= SIG_LEN_MAX);

  // parse step
  always_comb begin
    phase_nxt    = phase_r;
    decl_len_nxt = decl_len_r;
    part_rem_nxt = part_rem_r;
    fbz_nxt      = fbz_r;
    r_value_nxt  = r_value_r;
    s_value_nxt  = s_value_r;
    failed_nxt   = fail_pre;
    if (!fail_pre) begin
      unique case (phase_r)
        PH_HDR_TAG: begin
          if (byte_r != SEQ_TAG) failed_nxt = 1'b1;
          else phase_nxt = PH_HDR_LEN;
        end
        PH_HDR_LEN: begin
          decl_len_nxt = byte_r;
          phase_nxt    = PH_R_TAG;
        end
        PH_R_TAG: begin
          if (byte_r != INT_TAG) failed_nxt = 1'b1;
          else phase_nxt = PH_R_LEN;
        end
        PH_R_LEN: begin
          if (len_bad) begin
            failed_nxt = 1'b1;
          end else begin
            part_rem_nxt = byte_r[5:0];
            fbz_nxt      = 1'b0;
            phase_nxt    = PH_R_DATA;
          end
        end
        PH_R_DATA: begin
          failed_nxt   = td_fail;
          fbz_nxt      = td_fbz;
          r_value_nxt  = acc_shift;
          part_rem_nxt = td_rem;
          if (td_rem == 6'd0) phase_nxt = PH_S_TAG;
        end
        PH_S_TAG: begin
          if (byte_r != INT_TAG) failed_nxt = 1'b1;
          else phase_nxt = PH_S_LEN;
        end
        PH_S_LEN: begin
          if (len_bad) begin
            failed_nxt = 1'b1;
          end else begin
            part_rem_nxt = byte_r[5:0];
            fbz_nxt      = 1'b0;
            phase_nxt    = PH_S_DATA;
          end
        end
        PH_S_DATA: begin
          if (part_rem_r == 6'd0) begin
            failed_nxt = 1'b1;
          end else begin
            failed_nxt   = td_fail;
            fbz_nxt      = td_fbz;
            s_value_nxt  = acc_shift;
            part_rem_nxt = td_rem;
          end
        end
        default: failed_nxt = 1'b1;
      endcase
    end
  end

  // byte count, saturating at the maximum signature length
  assign total = {1'b0, byte_count_r} + 8'd1;
  assign byte_count_nxt = (byte_count_r < SIG_LEN_MAX) ? byte_count_r + 7'd1 : byte_count_r;

  // final checks; r only moves in its data phase, so its stored value is final here
  assign sig_ok = !failed_nxt && (phase_nxt == PH_S_DATA) && (part_rem_nxt == 6'd0) &&
                  (total >= SIG_LEN_MIN) && (total <= {1'b0, SIG_LEN_MAX}) &&
                  (decl_len_nxt == total - 8'd2) &&
                  (r_value_r < GROUP_ORDER) && (s_value_nxt < GROUP_ORDER);

  always_comb begin
    if (!sig_ok) verdict_nxt = VERDICT_INVALID;
    else if (s_value_nxt <= GROUP_HALF) verdict_nxt = VERDICT_LOW_S;
    else verdict_nxt = VERDICT_CANONICAL;
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_v_r <= 1'b1;
    end else if (proc) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_sig_byte;
      last_r <= in_last_byte;
    end
  end

  // parser state, cleared after each final byte
  always_ff @(posedge clk) begin
    if (!rst_n || (proc && last_r)) begin
      byte_count_r <= '0;
      decl_len_r   <= '0;
      phase_r      <= PH_HDR_TAG;
      part_rem_r   <= '0;
      fbz_r        <= 1'b0;
      r_value_r    <= '0;
      s_value_r    <= '0;
      failed_r     <= 1'b0;
    end else if (proc) begin
      byte_count_r <= byte_count_nxt;
      decl_len_r   <= decl_len_nxt;
      phase_r      <= phase_nxt;
      part_rem_r   <= part_rem_nxt;
      fbz_r        <= fbz_nxt;
      r_value_r    <= r_value_nxt;
      s_value_r    <= s_value_nxt;
      failed_r     <= failed_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (proc && last_r) begin
      out_v_r <= 1'b1;
    end else if (out_ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && last_r) verdict_r <= verdict_nxt;
  end

  // byte count never runs past the saturation point
  a_count_sat: assert property (@(posedge clk) disable iff (!rst_n)
    byte_count_r <= SIG_LEN_MAX)
    else $error("byte count beyond maximum signature length");

  // integer data still due never exceeds the longest integer
  a_rem_max: assert property (@(posedge clk) disable iff (!rst_n)
    part_rem_r <= PART_LEN_MAX)
    else $error("integer remaining length out of range");

  // input side stalls only behind a final byte waiting for the result register
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (in_v_r && last_r && out_v_r && !out_ready))
    else $error("input stalled without a blocked final byte");

  // a processed final byte leaves the parser at the header tag with an empty count
  a_reset_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && last_r) |=> (byte_count_r == 7'd0 && phase_r == PH_HDR_TAG && !failed_r
                          && out_v_r))
    else $error("parser not cleared after final byte");

  // a non-invalid verdict needs s below the group order
  a_low_s: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && last_r && verdict_nxt != VERDICT_INVALID) |-> (s_value_nxt < GROUP_ORDER))
    else $error("valid verdict with s not below the group order");

endmodule
